// ----- rtl/sgr_pkg.sv -----
// Shared widths, phase encoding and SGR code constants for the attribute decoder.
package sgr_pkg;

  localparam int unsigned ValueW = 17;
  localparam int unsigned AfterW = 4;
  localparam int unsigned AttrW  = 4;
  localparam int unsigned IndexW = 8;
  localparam int unsigned SkipW  = 2;

  typedef logic signed [ValueW-1:0] param_value_t;
  typedef logic [AfterW-1:0]        params_after_t;
  typedef logic [AttrW-1:0]         attr_t;
  typedef logic [IndexW-1:0]        pal_index_t;
  typedef logic [SkipW-1:0]         skip_t;
  typedef logic [15:0]              code_t;

  // Extended colour progress, one-hot.
  typedef enum logic [4:0] {
    PH_NONE   = 5'b00001,
    PH_FG_SEL = 5'b00010,
    PH_BG_SEL = 5'b00100,
    PH_FG_IDX = 5'b01000,
    PH_BG_IDX = 5'b10000
  } ext_phase_t;

  localparam attr_t ATTR_BOLD      = 4'b0001;
  localparam attr_t ATTR_UNDERLINE = 4'b0010;
  localparam attr_t ATTR_BLINK     = 4'b0100;
  localparam attr_t ATTR_INVERSE   = 4'b1000;

  localparam code_t CODE_RESET       = 16'd0;
  localparam code_t CODE_BOLD        = 16'd1;
  localparam code_t CODE_UNDERLINE   = 16'd4;
  localparam code_t CODE_BLINK       = 16'd5;
  localparam code_t CODE_INVERSE     = 16'd7;
  localparam code_t CODE_NO_BOLD     = 16'd22;
  localparam code_t CODE_NO_UNDER    = 16'd24;
  localparam code_t CODE_NO_BLINK    = 16'd25;
  localparam code_t CODE_NO_INVERSE  = 16'd27;
  localparam code_t CODE_FG_BASE     = 16'd30;
  localparam code_t CODE_FG_LAST     = 16'd37;
  localparam code_t CODE_FG_EXT      = 16'd38;
  localparam code_t CODE_FG_DEFAULT  = 16'd39;
  localparam code_t CODE_BG_BASE     = 16'd40;
  localparam code_t CODE_BG_LAST     = 16'd47;
  localparam code_t CODE_BG_EXT      = 16'd48;
  localparam code_t CODE_BG_DEFAULT  = 16'd49;
  localparam code_t CODE_FG_HI_BASE  = 16'd90;
  localparam code_t CODE_FG_HI_LAST  = 16'd97;
  localparam code_t CODE_BG_HI_BASE  = 16'd100;
  localparam code_t CODE_BG_HI_LAST  = 16'd107;

  localparam code_t SEL_RGB   = 16'd2;
  localparam code_t SEL_INDEX = 16'd5;

  localparam skip_t         RGB_SKIP      = 2'd3;
  localparam params_after_t EXT_MIN_AFTER = 4'd2;
  localparam pal_index_t    HI_PAL_OFFSET = 8'd8;

endpackage

// ----- rtl/sgr_if.sv -----
// Valid/ready channel interfaces for parameter requests and attribute results.
interface sgr_in_if import sgr_pkg::*; ();
  logic          valid;
  logic          ready;
  param_value_t  param_value;
  params_after_t params_after;

  modport source (output valid, output param_value, output params_after, input ready);
  modport sink   (input valid, input param_value, input params_after, output ready);
endinterface

interface sgr_out_if import sgr_pkg::*; ();
  logic       valid;
  logic       ready;
  attr_t      attributes;
  logic       fg_is_palette;
  pal_index_t fg_palette_index;
  logic       bg_is_palette;
  pal_index_t bg_palette_index;

  modport source (output valid, output attributes, output fg_is_palette,
                  output fg_palette_index, output bg_is_palette,
                  output bg_palette_index, input ready);
  modport sink   (input valid, input attributes, input fg_is_palette,
                  input fg_palette_index, input bg_is_palette,
                  input bg_palette_index, output ready);
endinterface

// ----- rtl/sgr_attribute_decoder.sv -----
// SGR parameter decoder: input register, combinational decode, state/result register.
// An accepted request is held in the input register, then decoded into the state/result register.
// Throughput: one parameter per cycle while the output is not back-pressured; the state
//   update of one parameter is combinational decode logic, so consecutive parameters chain without gaps.
// Reset (rst_n low, synchronous): attributes and colours cleared to default,
//   no extended colour or skip pending, both pipeline stages empty.
module sgr_attribute_decoder
  import sgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sgr_in_if.sink     in_ch,
  sgr_out_if.source  out_ch
);

  logic          s1_valid_r;
  param_value_t  s1_value_r;
  params_after_t s1_after_r;

  logic          out_valid_r;

  attr_t      attr_r, attr_nxt;
  logic       fg_kind_r, fg_kind_nxt;
  pal_index_t fg_idx_r, fg_idx_nxt;
  logic       bg_kind_r, bg_kind_nxt;
  pal_index_t bg_idx_r, bg_idx_nxt;
  ext_phase_t phase_r, phase_nxt;
  skip_t      skip_r, skip_nxt;

  logic  decode_fire;
  logic  in_fire;
  logic  is_empty;
  logic  is_pos;
  code_t val;
  logic  run_code;

  assign decode_fire = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || decode_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign is_empty = (s1_value_r == -17'sd1);
  assign is_pos   = !s1_value_r[ValueW-1];
  assign val      = s1_value_r[15:0];

  always_comb begin
    attr_nxt    = attr_r;
    fg_kind_nxt = fg_kind_r;
    fg_idx_nxt  = fg_idx_r;
    bg_kind_nxt = bg_kind_r;
    bg_idx_nxt  = bg_idx_r;
    phase_nxt   = phase_r;
    skip_nxt    = skip_r;
    run_code    = 1'b0;

    if (skip_r != '0) begin
      skip_nxt = skip_r - 2'd1;
    end else begin
      case (phase_r)
        PH_FG_SEL, PH_BG_SEL: begin
          if (is_pos && val == SEL_INDEX) begin
            phase_nxt = (phase_r == PH_FG_SEL) ? PH_FG_IDX : PH_BG_IDX;
          end else if (is_pos && val == SEL_RGB) begin
            phase_nxt = PH_NONE;
            skip_nxt  = RGB_SKIP;
          end else begin
            phase_nxt = PH_NONE;
            run_code  = 1'b1;
          end
        end
        PH_FG_IDX: begin
          fg_kind_nxt = 1'b1;
          fg_idx_nxt  = s1_value_r[IndexW-1:0];
          phase_nxt   = PH_NONE;
        end
        PH_BG_IDX: begin
          bg_kind_nxt = 1'b1;
          bg_idx_nxt  = s1_value_r[IndexW-1:0];
          phase_nxt   = PH_NONE;
        end
        default: begin
          phase_nxt = PH_NONE;
          run_code  = 1'b1;
        end
      endcase
    end

    if (run_code) begin
      if (is_empty || (is_pos && val == CODE_RESET)) begin
        attr_nxt    = '0;
        fg_kind_nxt = 1'b0;
        fg_idx_nxt  = '0;
        bg_kind_nxt = 1'b0;
        bg_idx_nxt  = '0;
      end else if (is_pos) begin
        case (val) inside
          CODE_BOLD:       attr_nxt = attr_r | ATTR_BOLD;
          CODE_UNDERLINE:  attr_nxt = attr_r | ATTR_UNDERLINE;
          CODE_BLINK:      attr_nxt = attr_r | ATTR_BLINK;
          CODE_INVERSE:    attr_nxt = attr_r | ATTR_INVERSE;
          CODE_NO_BOLD:    attr_nxt = attr_r & ~ATTR_BOLD;
          CODE_NO_UNDER:   attr_nxt = attr_r & ~ATTR_UNDERLINE;
          CODE_NO_BLINK:   attr_nxt = attr_r & ~ATTR_BLINK;
          CODE_NO_INVERSE: attr_nxt = attr_r & ~ATTR_INVERSE;
          [CODE_FG_BASE:CODE_FG_LAST]: begin
            fg_kind_nxt = 1'b1;
            fg_idx_nxt  = val[IndexW-1:0] - CODE_FG_BASE[IndexW-1:0];
          end
          [CODE_BG_BASE:CODE_BG_LAST]: begin
            bg_kind_nxt = 1'b1;
            bg_idx_nxt  = val[IndexW-1:0] - CODE_BG_BASE[IndexW-1:0];
          end
          [CODE_FG_HI_BASE:CODE_FG_HI_LAST]: begin
            fg_kind_nxt = 1'b1;
            fg_idx_nxt  = val[IndexW-1:0] - CODE_FG_HI_BASE[IndexW-1:0] + HI_PAL_OFFSET;
          end
          [CODE_BG_HI_BASE:CODE_BG_HI_LAST]: begin
            bg_kind_nxt = 1'b1;
            bg_idx_nxt  = val[IndexW-1:0] - CODE_BG_HI_BASE[IndexW-1:0] + HI_PAL_OFFSET;
          end
          CODE_FG_DEFAULT: fg_kind_nxt = 1'b0;
          CODE_BG_DEFAULT: bg_kind_nxt = 1'b0;
          CODE_FG_EXT: begin
            if (s1_after_r >= EXT_MIN_AFTER) phase_nxt = PH_FG_SEL;
          end
          CODE_BG_EXT: begin
            if (s1_after_r >= EXT_MIN_AFTER) phase_nxt = PH_BG_SEL;
          end
          default: ;
        endcase
      end
    end

    // drop anything pending at the end of the sequence
    if (s1_after_r == '0) begin
      phase_nxt = PH_NONE;
      skip_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_value_r <= in_ch.param_value;
      s1_after_r <= in_ch.params_after;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (decode_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // state doubles as the result register: it only advances when a result loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r    <= '0;
      fg_kind_r <= 1'b0;
      fg_idx_r  <= '0;
      bg_kind_r <= 1'b0;
      bg_idx_r  <= '0;
      phase_r   <= PH_NONE;
      skip_r    <= '0;
    end else if (decode_fire) begin
      attr_r    <= attr_nxt;
      fg_kind_r <= fg_kind_nxt;
      fg_idx_r  <= fg_idx_nxt;
      bg_kind_r <= bg_kind_nxt;
      bg_idx_r  <= bg_idx_nxt;
      phase_r   <= phase_nxt;
      skip_r    <= skip_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.attributes       = attr_r;
  assign out_ch.fg_is_palette    = fg_kind_r;
  assign out_ch.fg_palette_index = fg_idx_r;
  assign out_ch.bg_is_palette    = bg_kind_r;
  assign out_ch.bg_palette_index = bg_idx_r;

endmodule
